/* design/nfa_sa_pkg.sv */
// Package for the NFA string acceptor: item formats, op codes and the
// status structs passed between the sequencer and the top level.
// No dependencies; every other design file imports it.
package nfa_sa_pkg;

    // Fixed field widths of the input and result items.
    localparam int STATE_FW = 7;
    localparam int SYM_FW   = 8;
    localparam int LIVE_W   = 64;

    // Item op codes.
    typedef enum logic [1:0] {
        OP_ADD_TRANS   = 2'd0,
        OP_MARK_ACCEPT = 2'd1,
        OP_RESTART     = 2'd2,
        OP_FEED        = 2'd3
    } t_op;

    // One input item.
    typedef struct packed {
        t_op                 op;
        logic [STATE_FW-1:0] from_state;
        logic [STATE_FW-1:0] to_state;
        logic [SYM_FW-1:0]   symbol;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic              accepting;
        logic              no_live_state;
        logic [LIVE_W-1:0] live_states;
    } t_out_item;

    // Result offered by the sequencer to the output register.
    typedef struct packed {
        logic      valid;
        t_out_item data;
    } t_res;

    // Row memory strobes.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

/* design/nfa_sa_if.sv */
// Valid/ready channel interfaces for the input and result items.
// Depends on nfa_sa_pkg for the payload types.
interface nfa_sa_in_if import nfa_sa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nfa_sa_out_if import nfa_sa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/nfa_sa_row_mem.sv */
// Transition row memory: one write port and one read port with registered
// read data. Depends on nfa_sa_pkg for the strobe struct.
module nfa_sa_row_mem import nfa_sa_pkg::*; #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/nfa_sa_seq.sv */
// Sequencer of the NFA acceptor: clearing pass, item decode, row
// read-modify-write and the row-by-row OR scan for a symbol step.
// Depends on nfa_sa_pkg; drives nfa_sa_row_mem.
module nfa_sa_seq import nfa_sa_pkg::*; #(
    parameter int NUM_STATES  = 64,
    parameter int NUM_SYMBOLS = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  t_in_item                               i_in_data,
    output logic                                   o_in_ready,
    output t_mem_ctl                               o_mem_ctl,
    output logic [$clog2(NUM_SYMBOLS)+$clog2(NUM_STATES)-1:0] o_mem_waddr,
    output logic [NUM_STATES-1:0]                  o_mem_wdata,
    output logic [$clog2(NUM_SYMBOLS)+$clog2(NUM_STATES)-1:0] o_mem_raddr,
    input  logic [NUM_STATES-1:0]                  i_mem_rdata,
    output t_res                                   o_res,
    input  logic                                   i_res_ready
);

    localparam int IDX_W  = $clog2(NUM_STATES);
    localparam int SYM_W  = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W = SYM_W + IDX_W;
    localparam int ROWS   = NUM_SYMBOLS * (2 ** IDX_W);
    localparam logic [NUM_STATES-1:0] START_SET = NUM_STATES'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    t_in_item              r_item, n_item;
    logic [NUM_STATES-1:0] r_live, n_live;
    logic [NUM_STATES-1:0] r_accset, n_accset;
    logic [NUM_STATES-1:0] r_acc, n_acc;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_hit, n_hit;
    logic [ADDR_W-1:0]     r_clr, n_clr;

    logic              in_src_ok;
    logic              in_dst_ok;
    logic              in_sym_ok;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] item_addr;
    logic [ADDR_W-1:0] scan_addr;

    // Range checks and row addresses ({symbol, source - 1}).
    assign in_src_ok = (i_in_data.from_state != '0)
                    && (i_in_data.from_state <= STATE_FW'(NUM_STATES));
    assign in_dst_ok = (i_in_data.to_state != '0)
                    && (i_in_data.to_state <= STATE_FW'(NUM_STATES));
    assign in_sym_ok = {1'b0, i_in_data.symbol} < (SYM_FW + 1)'(NUM_SYMBOLS);
    assign in_addr   = {i_in_data.symbol[SYM_W-1:0],
                        IDX_W'(i_in_data.from_state - STATE_FW'(1))};
    assign item_addr = {r_item.symbol[SYM_W-1:0],
                        IDX_W'(r_item.from_state - STATE_FW'(1))};
    assign scan_addr = {r_item.symbol[SYM_W-1:0], r_idx};

    // Next-state and memory strobe logic.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_live      = r_live;
        n_accset    = r_accset;
        n_acc       = r_acc;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_clr       = r_clr;
        o_in_ready  = 1'b0;
        o_mem_ctl   = '0;
        o_mem_waddr = item_addr;
        o_mem_wdata = '0;
        o_mem_raddr = scan_addr;
        case (r_state)
            S_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_waddr     = r_clr;
                n_clr           = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_mem_raddr = in_addr;
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_DONE;
                    case (i_in_data.op)
                        OP_ADD_TRANS: begin
                            if (in_src_ok && in_dst_ok && in_sym_ok) begin
                                o_mem_ctl.rd_en = 1'b1;
                                n_state         = S_RMW;
                            end
                        end
                        OP_MARK_ACCEPT: begin
                            if (in_src_ok) begin
                                n_accset = r_accset | (START_SET
                                    << (i_in_data.from_state - STATE_FW'(1)));
                            end
                        end
                        OP_RESTART: begin
                            n_live = START_SET;
                        end
                        OP_FEED: begin
                            if (in_sym_ok) begin
                                n_acc   = '0;
                                n_idx   = '0;
                                n_hit   = 1'b0;
                                n_state = S_SCAN;
                            end else begin
                                n_live = '0;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RMW: begin
                // Merge the destination bit into the row just read.
                o_mem_ctl.wr_en = 1'b1;
                o_mem_wdata     = i_mem_rdata
                                | (START_SET << (r_item.to_state - STATE_FW'(1)));
                n_state         = S_DONE;
            end
            S_SCAN: begin
                // Read the row of each live source; OR the previous read in.
                o_mem_ctl.rd_en = r_live[r_idx];
                n_hit           = r_live[r_idx];
                if (r_hit) begin
                    n_acc = r_acc | i_mem_rdata;
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(NUM_STATES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_live  = r_hit ? (r_acc | i_mem_rdata) : r_acc;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_live   <= START_SET;
            r_accset <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_live   <= n_live;
            r_accset <= n_accset;
        end
        r_item <= n_item;
        r_acc  <= n_acc;
        r_idx  <= n_idx;
        r_hit  <= n_hit;
    end

    // Result offered once the item is finished.
    always_comb begin
        o_res.valid              = (r_state == S_DONE);
        o_res.data.accepting     = |(r_live & r_accset);
        o_res.data.no_live_state = ~|r_live;
        o_res.data.live_states   = LIVE_W'(r_live);
    end

`ifndef SYNTHESIS
    // A restart leaves only the start state live.
    a_restart_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.op == OP_RESTART)
        |=> (r_live == START_SET))
        else $error("restart did not set the live set to the start state");

    // The scan index never passes the last state.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= IDX_W'(NUM_STATES - 1)))
        else $error("scan index out of range");

    // The memory is only written during clearing or a row update.
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.wr_en |-> (r_state == S_CLEAR || r_state == S_RMW))
        else $error("unexpected row memory write");

    // A scan always starts with an empty accumulator.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_SCAN) |=> (r_acc == '0 && !r_hit))
        else $error("scan started with stale accumulator");
`endif

endmodule

/* design/nfa_string_acceptor_core.sv */
// Top level of the NFA string acceptor: sequencer, row memory and result
// output register. Depends on nfa_sa_pkg, nfa_sa_if, nfa_sa_seq and
// nfa_sa_row_mem.
//
// Usage: items enter on i_in (valid/ready) and one result item per input
// item leaves on o_out. Ops: add transition, mark accepting state, restart
// at state 1, feed a symbol. Each result carries the live set after the
// item, whether it meets the accepting set, and whether it is empty.
// After reset the block sweeps all NUM_SYMBOLS * 2**clog2(NUM_STATES) rows
// of the transition memory (16384 by default) to zero, one row per cycle;
// i_in.ready stays low meanwhile. Live set resets to state 1.
// From acceptance, mark and restart go straight to S_DONE, add transition
// passes S_RMW (row read-modify-write), and a symbol passes S_SCAN, which
// visits one memory row per cycle through the single read port (reading
// only for live states), then S_DRAIN, which folds in the last read; S_DONE
// offers the result to the output register. One item is in work at a time;
// the next is accepted in the cycle after the result moves on. If the
// receiver stalls, the result waits in the output register and the next
// item still enters, but its result waits its turn and input stalls.
module nfa_string_acceptor_core import nfa_sa_pkg::*; #(
    parameter int NUM_STATES  = 64,
    parameter int NUM_SYMBOLS = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nfa_sa_in_if.sink      i_in,
    nfa_sa_out_if.source   o_out
);

    localparam int IDX_W  = $clog2(NUM_STATES);
    localparam int SYM_W  = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W = SYM_W + IDX_W;
    localparam int ROWS   = NUM_SYMBOLS * (2 ** IDX_W);

    t_mem_ctl              mem_ctl;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [NUM_STATES-1:0] mem_wdata;
    logic [NUM_STATES-1:0] mem_rdata;
    t_res                  res;
    logic                  slot_free;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    nfa_sa_seq #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_data   (i_in.data),
        .o_in_ready  (i_in.ready),
        .o_mem_ctl   (mem_ctl),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res       (res),
        .i_res_ready (slot_free)
    );

    nfa_sa_row_mem #(
        .DEPTH  (ROWS),
        .ADDR_W (ADDR_W),
        .DATA_W (NUM_STATES)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: takes a result when empty or being drained.
    assign slot_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res.valid;
        end
        if (slot_free && res.valid) begin
            r_out_data <= res.data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

/* dv/nfa_string_acceptor_core_tb.sv */
// Self-checking testbench for nfa_string_acceptor_core: a directed table and then
// random automaton loads and symbol strings, checked against a live-set predictor or typed-in reports.
// Depends on nfa_sa_pkg, the nfa_sa_in_if/nfa_sa_out_if interfaces and the core RTL.
module nfa_string_acceptor_core_tb;
    import nfa_sa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_STATES    = 64;
    localparam int N_SYMBOLS   = 256;
    localparam int N_DIR       = 25;
    localparam int RAND_ITEMS  = 1850;
    localparam int PHASE_LEN   = 625;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;
    localparam bit [LIVE_W-1:0] STATE_MASK = {LIVE_W{1'b1}} >> (LIVE_W - N_STATES);

    // One row of the directed table; the report is typed in only where flagged.
    typedef struct {
        t_op             op;
        int              src;
        int              dst;
        int              sym;
        bit              typed;
        bit              acc;
        bit              empty;
        bit [LIVE_W-1:0] live;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    nfa_sa_in_if  in_if ();
    nfa_sa_out_if out_if ();

    nfa_string_acceptor_core #(
        .NUM_STATES  (N_STATES),
        .NUM_SYMBOLS (N_SYMBOLS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state: destination masks per symbol and source, accepting and live sets.
    bit [LIVE_W-1:0] dest_rows [N_SYMBOLS][N_STATES];
    bit [LIVE_W-1:0] accept_mask;
    bit [LIVE_W-1:0] live_now;

    t_out_item due_reports [$];
    int        items_taken;
    int        mismatches = 0;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_req;

    t_dir_row dir_rows [N_DIR] = '{
        // From reset nothing is loaded, so any symbol empties the live set.
        '{OP_FEED,        0,   0,   0, 1'b1, 1'b0, 1'b1, 64'h0},
        '{OP_RESTART,     0,   0,   0, 1'b1, 1'b0, 1'b0, 64'h1},
        // Out-of-range states are ignored when marking.
        '{OP_MARK_ACCEPT, 0,   0,   0, 1'b1, 1'b0, 1'b0, 64'h1},
        '{OP_MARK_ACCEPT, 127, 0,   0, 1'b1, 1'b0, 1'b0, 64'h1},
        '{OP_ADD_TRANS,   1,   64,  255, 1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   64,  1,   255, 1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   1,   1,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   1,   2,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   2,   64,  0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   0,   5,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   5,   65,  0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   127, 127, 170, 1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   1,   2,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_MARK_ACCEPT, 64,  0,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_MARK_ACCEPT, 64,  0,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_FEED,        0,   0,   255, 1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_FEED,        0,   0,   255, 1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_FEED,        0,   0,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_FEED,        0,   0,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_MARK_ACCEPT, 2,   0,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_FEED,        0,   0,   85,  1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_FEED,        0,   0,   0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_RESTART,     127, 127, 255, 1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_FEED,        127, 127, 0,   1'b0, 1'b0, 1'b0, 64'h0},
        '{OP_ADD_TRANS,   64,  64,  128, 1'b0, 1'b0, 1'b0, 64'h0}
    };

    function automatic bit state_in_range(input int unsigned s);
        return s >= 1 && s <= N_STATES;
    endfunction

    // Applies one item to the predicted automaton and returns the report it causes.
    function automatic t_out_item step_automaton(input t_in_item it);
        t_out_item       rep;
        bit [LIVE_W-1:0] next_live;
        int unsigned     src;
        int unsigned     dst;
        int unsigned     sym;
        src = 32'(it.from_state);
        dst = 32'(it.to_state);
        sym = 32'(it.symbol);
        case (it.op)
            OP_ADD_TRANS: begin
                if (state_in_range(src) && state_in_range(dst) && sym < N_SYMBOLS)
                    dest_rows[sym][src-1][dst-1] = 1'b1;
            end
            OP_MARK_ACCEPT: begin
                if (state_in_range(src))
                    accept_mask[src-1] = 1'b1;
            end
            OP_RESTART: begin
                live_now = LIVE_W'(1);
            end
            default: begin
                next_live = '0;
                if (sym < N_SYMBOLS) begin
                    for (int s = 0; s < N_STATES; s++)
                        if (live_now[s])
                            next_live |= dest_rows[sym][s];
                end
                live_now = next_live & STATE_MASK;
            end
        endcase
        rep.accepting     = (live_now & accept_mask) != '0;
        rep.no_live_state = live_now == '0;
        rep.live_states   = live_now;
        return rep;
    endfunction

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offers one item at a falling edge and waits until the core takes it.
    // Entered and left at a falling edge.
    task automatic offer_item(input t_in_item it, input bit typed, input t_out_item typed_rep);
        t_out_item rep;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        rep = step_automaton(it);
        due_reports.insert(due_reports.size(), typed ? typed_rep : rep);
        items_taken++;
        if (items_taken == PHASE_LEN) begin
            send_idle_pct = 53;
            recv_idle_pct = 32;
        end else if (items_taken == 2 * PHASE_LEN) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic send_op(input t_op op, input int src, input int dst, input int sym);
        t_in_item  it;
        t_out_item none;
        it.op         = op;
        it.from_state = STATE_FW'(src);
        it.to_state   = STATE_FW'(dst);
        it.symbol     = SYM_FW'(sym);
        none          = '0;
        offer_item(it, 1'b0, none);
    endtask

    // Holds the input idle until every expected report has come back.
    task automatic drain_reports();
        in_if.valid <= 1'b0;
        while (due_reports.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: reset, directed table, then random episodes.
    initial begin
        t_in_item  it;
        t_out_item rep;
        int        span;
        int        lo;
        int        alphabet [4];
        int        n_load;
        int        n_feed;
        bit        hold_done;
        bit        drain_done;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.data    = '0;
        accept_mask   = '0;
        live_now      = LIVE_W'(1);
        items_taken   = 0;
        send_idle_pct = 32;
        recv_idle_pct = 53;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table.
        for (int i = 0; i < N_DIR; i++) begin
            it.op                 = dir_rows[i].op;
            it.from_state         = STATE_FW'(dir_rows[i].src);
            it.to_state           = STATE_FW'(dir_rows[i].dst);
            it.symbol             = SYM_FW'(dir_rows[i].sym);
            rep.accepting         = dir_rows[i].acc;
            rep.no_live_state     = dir_rows[i].empty;
            rep.live_states       = dir_rows[i].live;
            offer_item(it, dir_rows[i].typed, rep);
        end

        // Random episodes: load a small automaton, restart, run a string over its alphabet.
        while (items_taken < N_DIR + RAND_ITEMS) begin
            if (!hold_done && items_taken > 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_taken > 900) begin
                drain_reports();
                drain_done = 1'b1;
            end
            span = ($urandom_range(0, 3) == 0) ? N_STATES : $urandom_range(2, 10);
            lo   = $urandom_range(1, N_STATES + 1 - span);
            foreach (alphabet[k])
                alphabet[k] = $urandom_range(0, N_SYMBOLS - 1);
            n_load = $urandom_range(0, 8);
            for (int k = 0; k < n_load; k++)
                send_op(OP_ADD_TRANS, $urandom_range(lo, lo + span - 1),
                        $urandom_range(lo, lo + span - 1), alphabet[$urandom_range(0, 3)]);
            repeat ($urandom_range(0, 2))
                send_op(OP_MARK_ACCEPT, $urandom_range(lo, lo + span - 1),
                        $urandom_range(0, 127), $urandom_range(0, 255));
            send_op(OP_RESTART, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 255));
            n_feed = $urandom_range(2, 12);
            for (int k = 0; k < n_feed; k++)
                send_op(OP_FEED, $urandom_range(0, 127), $urandom_range(0, 127),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                    : alphabet[$urandom_range(0, 3)]);
            // Occasional noise: any op with unrestricted fields.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_op(t_op'($urandom_range(0, 3)), $urandom_range(0, 127),
                            $urandom_range(0, 127), $urandom_range(0, 255));
            end
        end

        in_if.valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    initial begin
        bit hold_served;
        hold_served  = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_served = 1'b1;
            end
            out_if.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compares each accepted report with the oldest expected one.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected report %h", $time, out_if.data);
                mismatches++;
            end else begin
                want = due_reports.pop_front();
                if (out_if.data.accepting !== want.accepting) begin
                    $display("%0t: accepting expected %b actual %b", $time,
                             want.accepting, out_if.data.accepting);
                    mismatches++;
                end
                if (out_if.data.no_live_state !== want.no_live_state) begin
                    $display("%0t: no_live_state expected %b actual %b", $time,
                             want.no_live_state, out_if.data.no_live_state);
                    mismatches++;
                end
                if (out_if.data.live_states !== want.live_states) begin
                    $display("%0t: live_states expected %h actual %h", $time,
                             want.live_states, out_if.data.live_states);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog well beyond the slowest correct run, memory sweep included.
    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
